@@ src/lzw_compressor_12bit_macros.svh @@
// Assertion macros for the LZW compressor checker.
// Used by lzw_checker.sv; needs clk and arst_n in scope.
`ifndef LZW_COMPRESSOR_12BIT_MACROS_SVH
`define LZW_COMPRESSOR_12BIT_MACROS_SVH

// same-cycle implication
`define LZW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzw assertion failed");

// next-cycle implication
`define LZW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzw assertion failed");

`endif

@@ src/lzw_pkg.sv @@
// Shared types and constants of the LZW compressor.
// No dependencies.
`timescale 1ns / 1ps
package lzw_pkg;
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam int FIRST_CODE = 258;
	localparam int BUF_W      = 24;
	localparam int CNT_W      = 5;

	typedef struct packed {
		logic put;
		logic final_code;
	} pk_ctl_t;

	typedef struct packed {
		logic ready;
	} pk_stat_t;
endpackage

@@ src/lzw_hash_table.sv @@
// Dictionary memory: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
module lzw_hash_table #(
	parameter int CODE_WIDTH   = 12,
	parameter int HASH_ENTRIES = 4099
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(HASH_ENTRIES)-1:0] waddr,
	input  logic                            wvalid,
	input  logic [CODE_WIDTH-1:0]           wcode,
	input  logic [CODE_WIDTH-1:0]           wprefix,
	input  logic [7:0]                      wsuffix,
	input  logic [$clog2(HASH_ENTRIES)-1:0] raddr,
	output logic                            rvalid,
	output logic [CODE_WIDTH-1:0]           rcode,
	output logic [CODE_WIDTH-1:0]           rprefix,
	output logic [7:0]                      rsuffix
);
	localparam int WORD_W = 1 + 2 * CODE_WIDTH + 8;

	logic [WORD_W-1:0] mem [HASH_ENTRIES];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wvalid, wcode, wprefix, wsuffix};
		end
		rdata_q <= mem[raddr];
	end

	assign {rvalid, rcode, rprefix, rsuffix} = rdata_q;
endmodule

@@ src/lzw_packer.sv @@
// Bit packer: collects codes MSB first and hands out bytes through an
// output register. Depends on lzw_pkg.
`timescale 1ns / 1ps
module lzw_packer #(
	parameter int CODE_WIDTH = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lzw_pkg::pk_ctl_t        ctl,
	input  logic [CODE_WIDTH-1:0]   code,
	output lzw_pkg::pk_stat_t       stat,
	output logic                    dst_valid,
	input  logic                    dst_stall,
	output logic [7:0]              out_byte,
	output logic                    last
);
	import lzw_pkg::*;

	logic [BUF_W-1:0] buf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             final_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [CNT_W-1:0] sh;
	logic             slot_free;

	assign sh        = cnt_q - CNT_W'(8);
	assign slot_free = !valid_q || !dst_stall;
	assign stat.ready = cnt_q < CNT_W'(8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			cnt_q   <= '0;
			final_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.put) begin
				buf_q   <= (buf_q << CODE_WIDTH) | BUF_W'(code);
				cnt_q   <= cnt_q + CNT_W'(CODE_WIDTH);
				final_q <= ctl.final_code;
			end else if (cnt_q >= CNT_W'(8) && slot_free) begin
				buf_q <= buf_q & ((BUF_W'(1) << sh) - BUF_W'(1));
				cnt_q <= sh;
			end
			if (cnt_q >= CNT_W'(8) && slot_free && !ctl.put) begin
				valid_q <= 1'b1;
			end else if (!dst_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q >= CNT_W'(8) && slot_free && !ctl.put) begin
			byte_q <= 8'(buf_q >> sh);
			last_q <= final_q && (sh < CNT_W'(8));
		end
	end

	assign dst_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
endmodule

@@ src/lzw_compressor_12bit.sv @@
// LZW compressor, fixed-width codes packed MSB first.
// A stream's first byte is only latched; a later byte is hashed, reduced mod
// HASH_ENTRIES when needed, then read and compared in the dictionary, probing
// again on a collision; a miss puts the prefix code. An end item puts its
// codes in turn. A new item waits until the last is done. Reset: async,
// active low; then a clearing pass of HASH_ENTRIES entries, src_stall high.
`timescale 1ns / 1ps
module lzw_compressor_12bit #(
	parameter int CODE_WIDTH   = 12,
	parameter int HASH_ENTRIES = 4099
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic       op,
	input  logic [7:0] data_byte,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] out_byte,
	output logic       last
);
	import lzw_pkg::*;

	function automatic int red_steps(int cw, int h);
		int n;
		n = 0;
		while ((longint'(h) << n) < (longint'(1) << cw)) begin
			n++;
		end
		return n;
	endfunction

	localparam int IDX_W     = $clog2(HASH_ENTRIES);
	localparam int RW        = CODE_WIDTH + IDX_W;
	localparam int RED_STEPS = red_steps(CODE_WIDTH, HASH_ENTRIES);
	localparam int RC_W      = $clog2(RED_STEPS + 2);
	localparam logic [IDX_W:0] H_V = (IDX_W + 1)'(HASH_ENTRIES);
	localparam logic [CODE_WIDTH-1:0] LAST_CODE = {{(CODE_WIDTH - 1){1'b1}}, 1'b0};

	typedef enum logic [6:0] {
		S_CLR   = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RED   = 7'b0000100,
		S_RD    = 7'b0001000,
		S_CMP   = 7'b0010000,
		S_PUT   = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		PH_PREFIX = 2'd0,
		PH_ENDC   = 2'd1,
		PH_ZERO   = 2'd2
	} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic [IDX_W-1:0]     clr_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     tries_q;
	logic [RW-1:0]        red_q;
	logic [RC_W-1:0]      red_cnt_q;
	logic [CODE_WIDTH-1:0] cur_q;
	logic [CODE_WIDTH-1:0] nfc_q;
	logic [CODE_WIDTH-1:0] emit_q;
	logic                 present_q;
	logic                 is_end_q;
	logic [7:0]           byte_q;

	logic                 accept;
	logic [RW-1:0]        hash;
	logic [RW-1:0]        red_sub;
	logic [IDX_W:0]       step;
	logic [IDX_W-1:0]     idx_next;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic                 rd_valid;
	logic [CODE_WIDTH-1:0] rd_code;
	logic [CODE_WIDTH-1:0] rd_prefix;
	logic [7:0]           rd_suffix;
	logic                 hit;
	logic                 insert;
	pk_ctl_t              pk_ctl;
	pk_stat_t             pk_stat;
	logic [CODE_WIDTH-1:0] pk_code;

	assign src_stall = state_q != S_IDLE;
	assign accept    = src_valid && !src_stall;
	assign hash      = RW'({data_byte, {(CODE_WIDTH - 8){1'b0}}} ^ cur_q);
	assign red_sub   = RW'(HASH_ENTRIES) << (red_cnt_q - RC_W'(1));

	always_comb begin
		step = (idx_q == '0) ? (IDX_W + 1)'(1) : H_V - (IDX_W + 1)'(idx_q);
		if ((IDX_W + 1)'(idx_q) >= step) begin
			idx_next = IDX_W'((IDX_W + 1)'(idx_q) - step);
		end else begin
			idx_next = IDX_W'((IDX_W + 1)'(idx_q) + H_V - step);
		end
	end

	assign hit    = rd_valid && rd_prefix == cur_q && rd_suffix == byte_q;
	assign insert = state_q == S_CMP && !rd_valid && nfc_q <= LAST_CODE;
	assign mem_we    = state_q == S_CLR || insert;
	assign mem_waddr = (state_q == S_CLR) ? clr_q : idx_q;

	always_comb begin
		case (phase_q)
			PH_PREFIX: pk_code = emit_q;
			PH_ENDC:   pk_code = '1;
			PH_ZERO:   pk_code = '0;
			default:   pk_code = '0;
		endcase
		pk_ctl.put        = state_q == S_PUT && pk_stat.ready;
		pk_ctl.final_code = !is_end_q || phase_q == PH_ZERO;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			phase_q   <= PH_PREFIX;
			clr_q     <= '0;
			cur_q     <= '0;
			nfc_q     <= CODE_WIDTH'(FIRST_CODE);
			present_q <= 1'b0;
			is_end_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(HASH_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (op == OP_END) begin
							is_end_q  <= 1'b1;
							phase_q   <= present_q ? PH_PREFIX : PH_ENDC;
							present_q <= 1'b0;
							cur_q     <= '0;
							state_q   <= S_PUT;
						end else if (!present_q) begin
							cur_q     <= CODE_WIDTH'(data_byte);
							present_q <= 1'b1;
						end else if (RED_STEPS == 0) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					if (red_cnt_q == '0) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						cur_q   <= rd_code;
						state_q <= S_IDLE;
					end else if (!rd_valid || tries_q == IDX_W'(HASH_ENTRIES - 1)) begin
						if (insert) begin
							nfc_q <= nfc_q + CODE_WIDTH'(1);
						end
						cur_q    <= CODE_WIDTH'(byte_q);
						is_end_q <= 1'b0;
						phase_q  <= PH_PREFIX;
						state_q  <= S_PUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_PUT: begin
					if (pk_ctl.put) begin
						if (pk_ctl.final_code) begin
							state_q <= S_IDLE;
						end else if (phase_q == PH_PREFIX) begin
							phase_q <= PH_ENDC;
						end else begin
							phase_q <= PH_ZERO;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				byte_q    <= data_byte;
				emit_q    <= cur_q;
				tries_q   <= '0;
				red_q     <= hash;
				red_cnt_q <= RC_W'(RED_STEPS);
				idx_q     <= IDX_W'(hash);
			end
			S_RED: begin
				if (red_cnt_q != '0) begin
					if (red_q >= red_sub) begin
						red_q <= red_q - red_sub;
					end
					red_cnt_q <= red_cnt_q - RC_W'(1);
				end else begin
					idx_q <= IDX_W'(red_q);
				end
			end
			S_CMP: begin
				emit_q <= cur_q;
				if (rd_valid && !hit) begin
					idx_q   <= idx_next;
					tries_q <= tries_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	lzw_hash_table #(
		.CODE_WIDTH   (CODE_WIDTH),
		.HASH_ENTRIES (HASH_ENTRIES)
	) u_table (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wvalid  (state_q != S_CLR),
		.wcode   (nfc_q),
		.wprefix (cur_q),
		.wsuffix (byte_q),
		.raddr   (idx_q),
		.rvalid  (rd_valid),
		.rcode   (rd_code),
		.rprefix (rd_prefix),
		.rsuffix (rd_suffix)
	);

	lzw_packer #(
		.CODE_WIDTH (CODE_WIDTH)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pk_ctl),
		.code      (pk_code),
		.stat      (pk_stat),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.out_byte  (out_byte),
		.last      (last)
	);
endmodule

@@ src/lzw_checker.sv @@
// Port-level checker for the LZW compressor, bound to the top level.
// Depends on lzw_compressor_12bit_macros.svh.
`timescale 1ns / 1ps
`include "lzw_compressor_12bit_macros.svh"
module lzw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       src_stall,
	input logic       dst_valid,
	input logic       dst_stall,
	input logic [7:0] out_byte,
	input logic       last
);
	`LZW_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(out_byte))
	`LZW_ASSERT_NEXT(a_last_hold, dst_valid && dst_stall, $stable(last))
	`LZW_ASSERT_NOW(a_clear_after_reset, $rose(arst_n), src_stall)
endmodule

bind lzw_compressor_12bit lzw_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_stall (src_stall),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.out_byte  (out_byte),
	.last      (last)
);
